### rtl/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### rtl/sdo_pkg.sv
// ----------------------------------------------------------------------------
// sdo_pkg
// Shared constants and helpers for the SDO transaction table.
// ----------------------------------------------------------------------------
package sdo_pkg;
    localparam int ENTRIES = 64;
    localparam int SW = 6;
    localparam logic [47:0] NEVER = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] K_DEFINE = 3'd0;
    localparam logic [2:0] K_RDREQ  = 3'd1;
    localparam logic [2:0] K_WRREQ  = 3'd2;
    localparam logic [2:0] K_RDRSP  = 3'd3;
    localparam logic [2:0] K_WRACK  = 3'd4;
    localparam logic [2:0] K_TICK   = 3'd5;
    localparam logic [2:0] K_GET    = 3'd6;

    localparam logic [2:0] R_DONE   = 3'd0;
    localparam logic [2:0] R_SENDRD = 3'd1;
    localparam logic [2:0] R_SENDWR = 3'd2;
    localparam logic [2:0] R_VALUE  = 3'd3;
    localparam logic [2:0] R_BUSY   = 3'd4;
    localparam logic [2:0] R_UNKNOWN = 3'd5;

    localparam logic [1:0] M_NONE  = 2'd0;
    localparam logic [1:0] M_READ  = 2'd1;
    localparam logic [1:0] M_WRITE = 2'd2;

    localparam logic [2:0] P_SUCCESS = 3'd0;
    localparam logic [2:0] P_WAIT    = 3'd1;
    localparam logic [2:0] P_READING = 3'd2;
    localparam logic [2:0] P_WRITING = 3'd3;
    localparam logic [2:0] P_CONFIRM = 3'd4;

    // one table row
    typedef struct packed {
        logic [15:0] idx;
        logic [7:0]  sub;
        logic [1:0]  size;
        logic        def;
        logic        msk;
        logic        note;
        logic [1:0]  mode;
        logic [2:0]  phase;
        logic [63:0] data;
        logic [47:0] deadline;
    } row_t;

    function automatic logic [63:0] width_mask(input logic [1:0] code);
        case (code)
            2'd0: width_mask = 64'h0000_0000_0000_00FF;
            2'd1: width_mask = 64'h0000_0000_0000_FFFF;
            2'd2: width_mask = 64'h0000_0000_FFFF_FFFF;
            default: width_mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    endfunction
endpackage

### rtl/sdo_transaction_table.sv
// ----------------------------------------------------------------------------
// sdo_transaction_table
// Table of SDO transfer entries in one row memory, driven by a sequencer.
// ----------------------------------------------------------------------------
// Define, request and get go from idle to the execute state and back; a get
// result, and a busy reject likewise, is registered there into the output.
// A response scans rows one a cycle for its key.
// A tick sweeps all 64 rows one a cycle while the output does not stall it,
// then takes a closing emit step; a result may wait on the output.
// Reset: a clearing pass writes the reset row to all 64 entries.
`include "assert_macros.svh"
module sdo_transaction_table import sdo_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [5:0]         entry,
    input  logic               checked,
    input  logic [15:0]        object_index,
    input  logic [7:0]         object_sub,
    input  logic [1:0]         size_code,
    input  logic               masked,
    input  logic [63:0]        value,
    input  logic signed [31:0] timeout,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         result_kind,
    output logic [5:0]         slot,
    output logic               success,
    output logic [15:0]        out_index,
    output logic [7:0]         out_sub,
    output logic [1:0]         out_size,
    output logic [63:0]        out_value,
    output logic               last
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;

    // row memory, one read port, one write port
    row_t mem [ENTRIES];
    row_t rd_data;
    logic             we;
    logic [SW-1:0]    waddr, raddr;
    row_t             wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data <= mem[raddr];
    end

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] ptr_reg, ptr_next;
    logic [47:0]   tick_reg, tick_next;
    // captured input
    logic [2:0]  k_reg;
    logic [5:0]  e_reg;
    logic        c_reg, m_reg;
    logic [15:0] i_reg;
    logic [7:0]  s_reg;
    logic [1:0]  z_reg;
    logic [63:0] v_reg;
    logic [31:0] t_reg;

    // output register
    logic        ov_reg, ov_next;
    logic [2:0]  rk_reg, rk_next;
    logic [5:0]  sl_reg, sl_next;
    logic        su_reg, su_next;
    logic [15:0] oi_reg, oi_next;
    logic [7:0]  os_reg, os_next;
    logic [1:0]  oz_reg, oz_next;
    logic [63:0] ovl_reg, ovl_next;
    logic        la_reg, la_next;
    // newest tick result, held until the next one or the sweep end
    logic        hv_reg, hv_next;
    logic [2:0]  hk_reg, hk_next;
    logic        hs_reg, hs_next;
    logic [15:0] hi_reg, hi_next;
    logic [7:0]  hb_reg, hb_next;
    logic [1:0]  hz_reg, hz_next;
    logic [63:0] hd_reg, hd_next;
    logic [5:0]  hl_reg, hl_next;

    logic  take;
    logic  out_free;
    row_t  r;
    logic  hit;
    logic [47:0] armed;
    logic [48:0] sum;
    logic  lastrow;
    // result of the current sweep row
    logic        nv;
    logic [2:0]  nk;
    logic        ns;

    assign in_ready = (state_reg == S_IDLE);
    assign take     = in_valid && in_ready;
    assign out_free = !ov_reg || out_ready;
    assign lastrow  = (ptr_reg == SW'(ENTRIES - 1));
    assign hit      = rd_data.def && rd_data.idx == i_reg && rd_data.sub == s_reg;
    assign sum      = {1'b0, rd_data.deadline} + {1'b0, tick_reg};
    assign armed    = (rd_data.deadline == NEVER || sum[48] || sum[47:0] == NEVER)
                      ? NEVER : sum[47:0];

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            k_reg <= kind; e_reg <= entry; c_reg <= checked; m_reg <= masked;
            i_reg <= object_index; s_reg <= object_sub; z_reg <= size_code;
            v_reg <= value; t_reg <= timeout;
        end
        rk_reg <= rk_next; sl_reg <= sl_next; su_reg <= su_next; oi_reg <= oi_next;
        os_reg <= os_next; oz_reg <= oz_next; ovl_reg <= ovl_next; la_reg <= la_next;
        hk_reg <= hk_next; hs_reg <= hs_next; hi_reg <= hi_next; hb_reg <= hb_next;
        hz_reg <= hz_next; hd_reg <= hd_next; hl_reg <= hl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ptr_reg   <= '0;
            tick_reg  <= '0;
            ov_reg    <= 1'b0;
            hv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            tick_reg  <= tick_next;
            ov_reg    <= ov_next;
            hv_reg    <= hv_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg; ptr_next = ptr_reg; tick_next = tick_reg;
        we = 1'b0; waddr = ptr_reg; raddr = ptr_reg;
        wdata = '0; wdata.deadline = NEVER;
        r = rd_data;
        nv = 1'b0; nk = R_DONE; ns = 1'b0;
        ov_next = ov_reg && !out_ready;
        rk_next = rk_reg; sl_next = sl_reg; su_next = su_reg; oi_next = oi_reg;
        os_next = os_reg; oz_next = oz_reg; ovl_next = ovl_reg; la_next = la_reg;
        hv_next = hv_reg; hk_next = hk_reg; hs_next = hs_reg; hi_next = hi_reg;
        hb_next = hb_reg; hz_next = hz_reg; hd_next = hd_reg; hl_next = hl_reg;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (lastrow)
                begin
                    state_next = S_IDLE;
                    ptr_next = '0;
                end
            end
            S_IDLE:
            begin
                raddr = entry;
                ptr_next = '0;
                if (take)
                begin
                    if (kind == K_RDRSP || kind == K_WRACK)
                    begin
                        raddr = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        if (kind == K_TICK)
                            raddr = '0;
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN:
            begin
                // rd_data holds row ptr; lowest matching row wins
                raddr = ptr_reg;
                if (hit)
                    state_next = S_EXEC;
                else if (lastrow)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1; rk_next = R_UNKNOWN; sl_next = '0; su_next = 1'b0;
                        oi_next = i_reg; os_next = s_reg; oz_next = '0; ovl_next = '0;
                        la_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                    raddr = ptr_reg + 1'b1;
                end
            end
            S_EXEC:
            begin
                waddr = (k_reg == K_TICK || k_reg == K_RDRSP || k_reg == K_WRACK)
                        ? ptr_reg : e_reg;
                raddr = waddr;
                state_next = S_IDLE;
                case (k_reg)
                    K_DEFINE:
                    begin
                        r.idx = i_reg; r.sub = s_reg; r.size = z_reg;
                        r.def = 1'b1; r.msk = m_reg; we = 1'b1;
                    end
                    K_RDREQ, K_WRREQ:
                    begin
                        if (r.mode != M_NONE)
                        begin
                            if (c_reg)
                            begin
                                if (out_free)
                                begin
                                    ov_next = 1'b1; rk_next = R_BUSY; sl_next = e_reg;
                                    su_next = 1'b0; oi_next = '0; os_next = '0;
                                    oz_next = '0; ovl_next = '0; la_next = 1'b1;
                                end
                                else
                                    state_next = S_EXEC;
                            end
                            else if (k_reg == K_WRREQ)
                            begin
                                r.data = v_reg; we = 1'b1;
                            end
                        end
                        else
                        begin
                            if (k_reg == K_WRREQ)
                                r.data = v_reg;
                            r.deadline = t_reg[31] ? NEVER : {17'd0, t_reg[30:0]};
                            r.note = c_reg; r.mode = k_reg[1:0]; r.phase = P_WAIT;
                            we = 1'b1;
                        end
                    end
                    K_RDRSP:
                    begin
                        if (r.mode != M_NONE)
                        begin
                            if (r.phase == P_READING)
                            begin
                                r.data = v_reg & width_mask(z_reg); r.phase = P_SUCCESS;
                            end
                            else if (r.phase == P_CONFIRM)
                                r.phase = ((v_reg & width_mask(z_reg)) ==
                                           (r.data & width_mask(z_reg)))
                                          ? P_SUCCESS : P_WRITING;
                            we = 1'b1;
                        end
                    end
                    K_WRACK:
                    begin
                        if (r.mode != M_NONE && r.phase == P_WRITING)
                        begin
                            r.phase = P_SUCCESS; we = 1'b1;
                        end
                    end
                    K_GET:
                    begin
                        if (out_free)
                        begin
                            ov_next = 1'b1; rk_next = R_VALUE; sl_next = e_reg;
                            su_next = 1'b0; oi_next = '0; os_next = '0; oz_next = '0;
                            ovl_next = rd_data.data; la_next = 1'b1;
                        end
                        else
                            state_next = S_EXEC;
                    end
                    K_TICK:
                    begin
                        // one sweep step for row ptr
                        if (r.mode != M_NONE)
                        begin
                            if (r.msk)
                                r.phase = P_SUCCESS;
                            if (r.phase == P_SUCCESS)
                            begin
                                r.mode = M_NONE;
                                nv = r.note; nk = R_DONE; ns = 1'b1;
                            end
                            else if (r.phase == P_WAIT)
                            begin
                                r.deadline = armed;
                                r.phase = (r.mode == M_READ) ? P_READING : P_WRITING;
                            end
                            else if (r.deadline != NEVER && tick_reg >= r.deadline)
                            begin
                                r.mode = M_NONE;
                                nv = r.note; nk = R_DONE;
                            end
                            else if (r.phase == P_READING || r.phase == P_CONFIRM)
                            begin
                                nv = 1'b1; nk = R_SENDRD;
                            end
                            else if (r.phase == P_WRITING)
                            begin
                                r.phase = P_CONFIRM;
                                nv = 1'b1; nk = R_SENDWR;
                            end
                        end
                        if (nv && hv_reg && !out_free)
                            state_next = S_EXEC;   // held result cannot move yet
                        else
                        begin
                            we = (rd_data.mode != M_NONE);
                            if (nv)
                            begin
                                // held result is not the final one
                                if (hv_reg)
                                begin
                                    ov_next = 1'b1; rk_next = hk_reg; sl_next = hl_reg;
                                    su_next = hs_reg; oi_next = hi_reg; os_next = hb_reg;
                                    oz_next = hz_reg; ovl_next = hd_reg; la_next = 1'b0;
                                end
                                hv_next = 1'b1; hk_next = nk; hl_next = ptr_reg;
                                hs_next = ns;
                                hi_next = (nk == R_DONE) ? 16'd0 : rd_data.idx;
                                hb_next = (nk == R_DONE) ? 8'd0 : rd_data.sub;
                                hz_next = (nk == R_SENDWR) ? rd_data.size : 2'd0;
                                hd_next = (nk == R_SENDWR)
                                          ? (rd_data.data & width_mask(rd_data.size))
                                          : 64'd0;
                            end
                            if (lastrow)
                                state_next = S_EMIT;
                            else
                            begin
                                ptr_next = ptr_reg + 1'b1;
                                raddr = ptr_reg + 1'b1;
                                state_next = S_EXEC;
                            end
                        end
                    end
                    default: ;
                endcase
                wdata = r;
            end
            S_EMIT:
            begin
                // release the held result as the final one, then count the tick
                if (!hv_reg || out_free)
                begin
                    if (hv_reg)
                    begin
                        ov_next = 1'b1; rk_next = hk_reg; sl_next = hl_reg;
                        su_next = hs_reg; oi_next = hi_reg; os_next = hb_reg;
                        oz_next = hz_reg; ovl_next = hd_reg; la_next = 1'b1;
                        hv_next = 1'b0;
                    end
                    if (tick_reg != NEVER)
                        tick_next = tick_reg + 1'b1;
                    ptr_next = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid   = ov_reg;
    assign result_kind = rk_reg;
    assign slot        = sl_reg;
    assign success     = su_reg;
    assign out_index   = oi_reg;
    assign out_sub     = os_reg;
    assign out_size    = oz_reg;
    assign out_value   = ovl_reg;
    assign last        = la_reg;

    `ASSERT_IMP(a_idle_no_take_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `ASSERT_NXT(a_take_leaves_idle, clk, rst_n, take, state_reg != S_IDLE)
    `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule
